[design/srpc_pkg.sv]
package srpc_pkg;

  // Defaults for the top-level parameters and the queue depth
  localparam int MOTORS_DEF        = 2;
  localparam int TICK_FREQ_DEF     = 84000000;
  localparam int POSITION_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int TGT_W    = 24;
  localparam int POS_W    = 24;
  localparam int PERIOD_W = 32;
  localparam int RATE_W   = 16;
  localparam int INC_W    = 7;
  localparam int LEVEL_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE  = 2'd2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PULSE = 2'd2;

  // Reset values, level limit and correction rate
  localparam logic [LEVEL_W-1:0]    RESET_LEVEL     = 3'd5;
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX       = 3'd6;
  localparam logic [CFG_DATA_W-1:0] RESET_BRAKE     = 16'd100;
  localparam logic [RATE_W-1:0]     RESET_RATE      = 16'd57600;
  localparam logic [RATE_W-1:0]     CORRECTION_RATE = 16'd64;
  localparam int                    RESET_BRAKE_PT  = 2;

  // Motion phase, as reported on motion_status
  typedef enum logic [2:0] {
    MS_STOPPED  = 3'd0,
    MS_STARTING = 3'd1,
    MS_FULL     = 3'd2,
    MS_BRAKING  = 3'd3,
    MS_CORRECT  = 3'd4
  } motion_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_MOVE  = 3'd0,
    OP_TICK  = 3'd1,
    OP_PULSE = 3'd2,
    OP_NOP   = 3'd3,
    OP_BAD   = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              motor;
    logic [RATE_W-1:0] max_rate;
    logic [INC_W-1:0]  rate_inc;
  } ctrl_t;

  typedef struct packed {
    logic                  write;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
    clamp_level = (lv > LEVEL_MAX) ? LEVEL_MAX : lv;
  endfunction

  function automatic logic [RATE_W-1:0] max_rate_of(input logic [LEVEL_W-1:0] lv);
    case (lv)
      3'd0: max_rate_of = 16'd0;
      3'd1: max_rate_of = 16'd1800;
      3'd2: max_rate_of = 16'd3600;
      3'd3: max_rate_of = 16'd7200;
      3'd4: max_rate_of = 16'd14400;
      3'd5: max_rate_of = 16'd28800;
      default: max_rate_of = 16'd57600;
    endcase
  endfunction

  function automatic logic [INC_W-1:0] rate_inc_of(input logic [LEVEL_W-1:0] lv);
    case (lv)
      3'd0: rate_inc_of = 7'd0;
      3'd1: rate_inc_of = 7'd2;
      3'd2: rate_inc_of = 7'd4;
      3'd3: rate_inc_of = 7'd8;
      3'd4: rate_inc_of = 7'd16;
      3'd5: rate_inc_of = 7'd32;
      default: rate_inc_of = 7'd64;
    endcase
  endfunction

endpackage

[design/srpc_if.sv]
interface srpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [srpc_pkg::CMD_W-1:0]  command;
  logic                        motor;
  logic [srpc_pkg::TGT_W-1:0]  target_steps;

  modport source (output valid, command, motor, target_steps, input ready);
  modport sink   (input valid, command, motor, target_steps, output ready);
endinterface

interface srpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    motion_status;
  logic                          motor_enable;
  logic                          period_valid;
  logic [srpc_pkg::PERIOD_W-1:0] timer_period;
  logic [srpc_pkg::POS_W-1:0]    position;
  logic                          move_rejected;

  modport source (output valid, motion_status, motor_enable, period_valid, timer_period,
                  position, move_rejected, input ready);
  modport sink   (input valid, motion_status, motor_enable, period_valid, timer_period,
                  position, move_rejected, output ready);
endinterface

[design/stepper_ramp_profile_controller.sv]
// Two-motor trapezoidal ramp controller. Each input transaction is a move
// start, a 1 ms ramp tick or a step-pulse-done event for one motor, and each
// one yields exactly one result transaction carrying the motion phase, driver
// enable, position and, when the step timer is reloaded, its new period
// (TICK_FREQ / rate - 1, all ones for a zero rate). Configuration (microstep
// level per motor, brake distance) is written through cfg_write/cfg_index/
// cfg_data while the block is idle. A front stage classifies each transaction
// and resolves the microstep tables and braking point into a two-entry queue;
// the back stage applies it to the per-motor state. A transaction that does
// not reload the timer is loaded into the result register as it leaves the
// queue. One that reloads the timer starts the radix-2 period divider in the
// back stage as it leaves the queue; the divider works out the quotient bit
// by bit, and the period is registered into the result register once the
// divider is done. The back stage takes the next queued transaction only
// once no division runs and the result register is free or being read. The
// front keeps accepting while the queue has room, so a waiting result does
// not block new input.
module stepper_ramp_profile_controller #(
  parameter int MOTORS        = srpc_pkg::MOTORS_DEF,
  parameter int TICK_FREQ     = srpc_pkg::TICK_FREQ_DEF,
  parameter int POSITION_BITS = srpc_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [srpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  srpc_in_if.sink                           in_ch,
  srpc_out_if.source                        out_ch
);

  localparam int ENTRY_W = $bits(srpc_pkg::ctrl_t) + 2 * POSITION_BITS;

  srpc_pkg::cfg_wr_t  cfg;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               full;
  logic               pop;
  logic [ENTRY_W-1:0] pop_data;
  logic               empty;

  // Bundle the configuration write for the front stage
  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: accept, classify, resolve tables and braking point
  srpc_front #(
    .MOTORS        (MOTORS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // Queue: decouple front and back so each side stalls on its own
  srpc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (srpc_pkg::QUEUE_DEPTH_DEF)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back: update motor state, divide for the timer period, hold the result
  srpc_back #(
    .MOTORS        (MOTORS),
    .TICK_FREQ     (TICK_FREQ),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .out_ch   (out_ch)
  );

endmodule

[design/srpc_front.sv]
module srpc_front #(
  parameter int MOTORS        = srpc_pkg::MOTORS_DEF,
  parameter int POSITION_BITS = srpc_pkg::POSITION_BITS_DEF,
  localparam int ENTRY_W      = $bits(srpc_pkg::ctrl_t) + 2 * POSITION_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  srpc_pkg::cfg_wr_t   cfg,
  srpc_in_if.sink             in_ch,
  output logic                push,
  output logic [ENTRY_W-1:0]  push_data,
  input  logic                full
);

  logic [srpc_pkg::LEVEL_W-1:0]    level0;
  logic [srpc_pkg::LEVEL_W-1:0]    level1;
  logic [srpc_pkg::CFG_DATA_W-1:0] brake_steps;

  srpc_pkg::ctrl_t              ctrl;
  logic [srpc_pkg::LEVEL_W-1:0] lv;
  logic [POSITION_BITS-1:0]     tgt;
  logic [POSITION_BITS-1:0]     brk;
  logic [31:0]                  tgt_ext;
  logic [31:0]                  bs_ext;
  logic [31:0]                  diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      level0      <= srpc_pkg::RESET_LEVEL;
      level1      <= srpc_pkg::RESET_LEVEL;
      brake_steps <= srpc_pkg::RESET_BRAKE;
    end else if (cfg.write) begin
      case (cfg.index)
        srpc_pkg::CFG_LEVEL0: begin
          level0 <= cfg.data[srpc_pkg::LEVEL_W-1:0];
        end
        srpc_pkg::CFG_LEVEL1: begin
          level1 <= cfg.data[srpc_pkg::LEVEL_W-1:0];
        end
        srpc_pkg::CFG_BRAKE: begin
          brake_steps <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    lv = srpc_pkg::clamp_level(in_ch.motor ? level1 : level0);
    ctrl.motor    = in_ch.motor;
    ctrl.max_rate = srpc_pkg::max_rate_of(lv);
    ctrl.rate_inc = srpc_pkg::rate_inc_of(lv);
    if (32'(in_ch.motor) >= 32'(MOTORS)) begin
      ctrl.op = srpc_pkg::OP_BAD;
    end else begin
      case (in_ch.command)
        srpc_pkg::CMD_MOVE:  ctrl.op = srpc_pkg::OP_MOVE;
        srpc_pkg::CMD_TICK:  ctrl.op = srpc_pkg::OP_TICK;
        srpc_pkg::CMD_PULSE: ctrl.op = srpc_pkg::OP_PULSE;
        default:             ctrl.op = srpc_pkg::OP_NOP;
      endcase
    end
    // Braking point saturates at zero for short moves
    tgt     = POSITION_BITS'(in_ch.target_steps);
    tgt_ext = 32'(tgt);
    bs_ext  = 32'(brake_steps);
    diff    = tgt_ext - bs_ext;
    brk     = (tgt_ext > bs_ext) ? POSITION_BITS'(diff) : '0;
    push_data = {ctrl, tgt, brk};
  end

endmodule

[design/srpc_fifo.sv]
module srpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = srpc_pkg::QUEUE_DEPTH_DEF,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[design/srpc_div.sv]
module srpc_div #(
  parameter int TICK_FREQ = srpc_pkg::TICK_FREQ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srpc_pkg::RATE_W-1:0]   divisor,
  output logic                          done,
  output logic [srpc_pkg::PERIOD_W-1:0] quotient
);

  localparam int QW = srpc_pkg::PERIOD_W;
  localparam int RW = srpc_pkg::RATE_W;
  localparam int NW = $clog2(QW);

  logic [QW-1:0] dq;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvsr;
  logic [NW-1:0] cnt;
  logic          busy;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          qbit;

  // One quotient bit per cycle, restoring form
  always_comb begin
    trial = {rem, dq[QW-1]};
    diff  = trial - {1'b0, dvsr};
    qbit  = (trial >= {1'b0, dvsr});
  end

  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= QW'(TICK_FREQ);
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      dq  <= {dq[QW-2:0], qbit};
      rem <= qbit ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/srpc_back.sv]
module srpc_back #(
  parameter int MOTORS        = srpc_pkg::MOTORS_DEF,
  parameter int TICK_FREQ     = srpc_pkg::TICK_FREQ_DEF,
  parameter int POSITION_BITS = srpc_pkg::POSITION_BITS_DEF,
  localparam int CTRL_W       = $bits(srpc_pkg::ctrl_t),
  localparam int ENTRY_W      = CTRL_W + 2 * POSITION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  output logic               pop,
  input  logic [ENTRY_W-1:0] pop_data,
  input  logic               empty,
  srpc_out_if.source         out_ch
);

  localparam int PB = POSITION_BITS;
  localparam int RW = srpc_pkg::RATE_W;

  typedef enum logic [1:0] {
    S_FETCH = 2'b01,
    S_DIV   = 2'b10
  } back_state_t;

  back_state_t st;

  srpc_pkg::motion_t motion_state  [MOTORS];
  logic [PB-1:0]     step_position [MOTORS];
  logic [PB-1:0]     target_count  [MOTORS];
  logic [PB-1:0]     brake_point   [MOTORS];
  logic [RW-1:0]     step_rate     [MOTORS];
  logic              enable_level  [MOTORS];

  srpc_pkg::ctrl_t ctrl;
  logic [PB-1:0]   e_tgt;
  logic [PB-1:0]   e_brk;
  logic            m_idx;

  srpc_pkg::motion_t cur_st, st_next;
  logic [PB-1:0]     cur_pos, pos_next, cur_tgt, tgt_next, cur_brk, brk_next;
  logic [PB-1:0]     pos_inc, pos_dec;
  logic [RW-1:0]     cur_rate, rate_next, rate_up, rate_dn;
  logic              cur_en, en_next;
  logic              reload, rejected;
  logic [31:0]       pos_ext;

  logic                          out_valid;
  logic [2:0]                    out_status;
  logic                          out_en;
  logic                          out_reload;
  logic [srpc_pkg::PERIOD_W-1:0] out_period;
  logic [srpc_pkg::POS_W-1:0]    out_pos;
  logic                          out_rej;
  logic                          rate_zero;

  logic                          slot_free;
  logic                          div_done;
  logic [srpc_pkg::PERIOD_W-1:0] div_q;

  assign ctrl  = srpc_pkg::ctrl_t'(pop_data[ENTRY_W-1 -: CTRL_W]);
  assign e_tgt = pop_data[2*PB-1 -: PB];
  assign e_brk = pop_data[PB-1:0];
  assign m_idx = (ctrl.op == srpc_pkg::OP_BAD) ? 1'b0 : ctrl.motor;

  assign slot_free = !out_valid || out_ch.ready;
  assign pop       = (st == S_FETCH) && !empty && slot_free;

  always_comb begin
    cur_st   = motion_state[m_idx];
    cur_pos  = step_position[m_idx];
    cur_tgt  = target_count[m_idx];
    cur_brk  = brake_point[m_idx];
    cur_rate = step_rate[m_idx];
    cur_en   = enable_level[m_idx];

    pos_inc = cur_pos + PB'(1);
    pos_dec = cur_pos - PB'(1);
    rate_up = cur_rate + RW'(ctrl.rate_inc);
    rate_dn = cur_rate - RW'(ctrl.rate_inc);

    st_next   = cur_st;
    pos_next  = cur_pos;
    tgt_next  = cur_tgt;
    brk_next  = cur_brk;
    rate_next = cur_rate;
    en_next   = cur_en;
    reload    = 1'b0;
    rejected  = 1'b0;

    case (ctrl.op)
      srpc_pkg::OP_MOVE: begin
        if (cur_st != srpc_pkg::MS_STOPPED) begin
          rejected = 1'b1;
        end else begin
          tgt_next = e_tgt;
          brk_next = e_brk;
          pos_next = '0;
          st_next  = srpc_pkg::MS_STARTING;
          en_next  = 1'b1;
          reload   = 1'b1;
        end
      end
      srpc_pkg::OP_TICK: begin
        if (cur_st == srpc_pkg::MS_STARTING) begin
          if (cur_rate < ctrl.max_rate) begin
            rate_next = rate_up;
            reload    = 1'b1;
          end else begin
            st_next = srpc_pkg::MS_FULL;
          end
        end else if (cur_st == srpc_pkg::MS_BRAKING) begin
          // Underflow past zero wraps above max rate; any rate above max rate is clamped to one
          rate_next = (rate_dn > ctrl.max_rate) ? RW'(1) : rate_dn;
          reload    = 1'b1;
        end
      end
      srpc_pkg::OP_PULSE: begin
        case (cur_st)
          srpc_pkg::MS_STARTING: begin
            pos_next = pos_inc;
          end
          srpc_pkg::MS_FULL: begin
            pos_next = pos_inc;
            if (pos_inc > cur_brk) begin
              st_next = srpc_pkg::MS_BRAKING;
            end
          end
          srpc_pkg::MS_BRAKING: begin
            pos_next = pos_inc;
            if (pos_inc == cur_tgt) begin
              st_next = srpc_pkg::MS_STOPPED;
              en_next = 1'b0;
            end else if (pos_inc > cur_tgt) begin
              st_next   = srpc_pkg::MS_CORRECT;
              rate_next = srpc_pkg::CORRECTION_RATE;
              reload    = 1'b1;
            end
          end
          srpc_pkg::MS_CORRECT: begin
            if (cur_pos > cur_tgt) begin
              pos_next = pos_dec;
            end else begin
              st_next = srpc_pkg::MS_STOPPED;
              en_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    pos_ext = 32'(pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        motion_state[i]  <= srpc_pkg::MS_STOPPED;
        step_position[i] <= '0;
        target_count[i]  <= '0;
        brake_point[i]   <= PB'(srpc_pkg::RESET_BRAKE_PT);
        step_rate[i]     <= srpc_pkg::RESET_RATE;
        enable_level[i]  <= 1'b0;
      end
    end else if (pop && ctrl.op != srpc_pkg::OP_BAD) begin
      motion_state[m_idx]  <= st_next;
      step_position[m_idx] <= pos_next;
      target_count[m_idx]  <= tgt_next;
      brake_point[m_idx]   <= brk_next;
      step_rate[m_idx]     <= rate_next;
      enable_level[m_idx]  <= en_next;
    end
  end

  srpc_div #(
    .TICK_FREQ (TICK_FREQ)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (pop && reload),
    .divisor  (rate_next),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_FETCH;
      out_valid <= 1'b0;
    end else begin
      case (st)
        S_FETCH: begin
          if (pop) begin
            out_valid <= !reload;
            if (reload) begin
              st <= S_DIV;
            end
          end else if (out_valid && out_ch.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            st        <= S_FETCH;
          end
        end
        default: begin
          st <= S_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (ctrl.op == srpc_pkg::OP_BAD) begin
        out_status <= '0;
        out_en     <= 1'b0;
        out_pos    <= '0;
      end else begin
        out_status <= st_next;
        out_en     <= en_next;
        out_pos    <= pos_ext[srpc_pkg::POS_W-1:0];
      end
      out_reload <= reload;
      out_rej    <= rejected;
      out_period <= '0;
      rate_zero  <= (rate_next == '0);
    end else if (div_done) begin
      out_period <= rate_zero ? '1 : div_q - srpc_pkg::PERIOD_W'(1);
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.motion_status = out_status;
  assign out_ch.motor_enable  = out_en;
  assign out_ch.period_valid  = out_reload;
  assign out_ch.timer_period  = out_period;
  assign out_ch.position      = out_pos;
  assign out_ch.move_rejected = out_rej;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("back popped an empty queue");

  a_no_result_in_div: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> !out_valid)
    else $error("result shown while period division runs");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == S_DIV))
    else $error("divider finished outside division state");

  a_enable_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_status == 3'(srpc_pkg::MS_STOPPED)) == !out_en))
    else $error("enable level disagrees with motion phase");

  a_period_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_reload) |-> (out_period == '0))
    else $error("timer period nonzero without reload");
`endif

endmodule

[verif/stepper_ramp_profile_controller_test.sv]
`timescale 1ns / 100ps

module stepper_ramp_profile_controller_test;
  import srpc_pkg::*;

  localparam int TICK_FREQ    = TICK_FREQ_DEF;
  localparam int RANDOM_ITEMS = 800;
  // Slowest legal run is roughly 850 transactions, each with a division, gap and stall,
  // plus phase drains; the limit is many times that.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]          status;
    logic                enable;
    logic                period_valid;
    logic [PERIOD_W-1:0] period;
    logic [POS_W-1:0]    position;
    logic                rejected;
  } ramp_result_t;

  // Per-motor ramp predictor plus the queue of results it has promised.
  class ramp_scoreboard;
    ramp_result_t          expected_results[$];
    motion_t               phase [2];
    logic [POS_W-1:0]      position [2];
    logic [POS_W-1:0]      target [2];
    logic [POS_W-1:0]      brake_point [2];
    logic [RATE_W-1:0]     rate [2];
    logic                  enable [2];
    logic [LEVEL_W-1:0]    level [2];
    logic [CFG_DATA_W-1:0] brake_steps;
    logic [RATE_W-1:0]     top_rate_tab [7];
    logic [RATE_W-1:0]     rate_step_tab [7];
    int                    mismatches;
    int                    results_checked;
    int                    zero_rate_reloads;
    int                    status_seen [5];

    function new();
      top_rate_tab  = '{16'd0, 16'd1800, 16'd3600, 16'd7200, 16'd14400, 16'd28800, 16'd57600};
      rate_step_tab = '{16'd0, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32, 16'd64};
      brake_steps = RESET_BRAKE;
      for (int i = 0; i < 2; i++) begin
        phase[i]       = MS_STOPPED;
        position[i]    = '0;
        target[i]      = '0;
        brake_point[i] = POS_W'(RESET_BRAKE_PT);
        rate[i]        = RESET_RATE;
        enable[i]      = 1'b0;
        level[i]       = RESET_LEVEL;
      end
      mismatches = 0;
      results_checked = 0;
      zero_rate_reloads = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LEVEL0: level[0] = data[LEVEL_W-1:0];
        CFG_LEVEL1: level[1] = data[LEVEL_W-1:0];
        CFG_BRAKE:  brake_steps = data;
        default: ;
      endcase
    endfunction

    function logic [PERIOD_W-1:0] period_for(logic [RATE_W-1:0] r);
      if (r == '0) return '1;
      return PERIOD_W'(TICK_FREQ / int'(r) - 1);
    endfunction

    // Apply one accepted transaction and queue the result it must produce.
    function void note_input(logic [CMD_W-1:0] cmd, logic m, logic [TGT_W-1:0] tgt);
      int                lv;
      logic              reload;
      logic              rej;
      logic [RATE_W-1:0] next_rate;
      ramp_result_t      res;
      lv = (level[m] > LEVEL_MAX) ? int'(LEVEL_MAX) : int'(level[m]);
      reload = 1'b0;
      rej = 1'b0;
      case (cmd)
        CMD_MOVE: begin
          if (phase[m] != MS_STOPPED) begin
            rej = 1'b1;
          end else begin
            target[m] = tgt;
            brake_point[m] = (tgt > POS_W'(brake_steps)) ? tgt - POS_W'(brake_steps) : '0;
            position[m] = '0;
            phase[m] = MS_STARTING;
            enable[m] = 1'b1;
            reload = 1'b1;
          end
        end
        CMD_TICK: begin
          if (phase[m] == MS_STARTING) begin
            if (rate[m] < top_rate_tab[lv]) begin
              rate[m] = rate[m] + rate_step_tab[lv];
              reload = 1'b1;
            end else begin
              phase[m] = MS_FULL;
            end
          end else if (phase[m] == MS_BRAKING) begin
            next_rate = rate[m] - rate_step_tab[lv];
            if (next_rate > top_rate_tab[lv]) next_rate = 16'd1;
            rate[m] = next_rate;
            reload = 1'b1;
          end
        end
        CMD_PULSE: begin
          case (phase[m])
            MS_STARTING: position[m] = position[m] + 1'b1;
            MS_FULL: begin
              position[m] = position[m] + 1'b1;
              if (position[m] > brake_point[m]) phase[m] = MS_BRAKING;
            end
            MS_BRAKING: begin
              position[m] = position[m] + 1'b1;
              if (position[m] == target[m]) begin
                phase[m] = MS_STOPPED;
                enable[m] = 1'b0;
              end else if (position[m] > target[m]) begin
                phase[m] = MS_CORRECT;
                rate[m] = CORRECTION_RATE;
                reload = 1'b1;
              end
            end
            MS_CORRECT: begin
              if (position[m] > target[m]) begin
                position[m] = position[m] - 1'b1;
              end else begin
                phase[m] = MS_STOPPED;
                enable[m] = 1'b0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res.status       = phase[m];
      res.enable       = enable[m];
      res.period_valid = reload;
      res.period       = reload ? period_for(rate[m]) : '0;
      res.position     = position[m];
      res.rejected     = rej;
      if (reload && rate[m] == '0) zero_rate_reloads++;
      expected_results.push_back(res);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endfunction

    function void check_result(ramp_result_t got);
      ramp_result_t want;
      if (expected_results.size() == 0) begin
        flag("unexpected result (status)", 32'hx, got.status);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      status_seen[want.status]++;
      if (got.status !== want.status) flag("motion_status", want.status, got.status);
      if (got.enable !== want.enable) flag("motor_enable", want.enable, got.enable);
      if (got.period_valid !== want.period_valid)
        flag("period_valid", want.period_valid, got.period_valid);
      if (got.period !== want.period) flag("timer_period", want.period, got.period);
      if (got.position !== want.position) flag("position", want.position, got.position);
      if (got.rejected !== want.rejected) flag("move_rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;          // phase runs with no gaps and no stalls
  int                    cycle_count = 0;
  int                    items_sent = 0;
  int                    settings_applied = 0;
  ramp_scoreboard        board;

  srpc_in_if  in_ch ();
  srpc_out_if out_ch ();

  stepper_ramp_profile_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung handshake anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               board.expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one transaction after a random gap and hold it until accepted. Valid is
  // left high so a back-to-back transaction never drops it within one step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic motor,
                           input logic [TGT_W-1:0] tgt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.motor        <= motor;
    in_ch.target_steps <= tgt;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(cmd, motor, tgt);
    items_sent++;
  endtask

  // Drop valid and wait until every promised result has come back, so the block
  // is idle and registers may be written.
  task automatic end_phase();
    in_ch.valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  function automatic logic [TGT_W-1:0] short_target();
    return ($urandom_range(0, 7) == 0) ? TGT_W'($urandom_range(0, 400))
                                       : TGT_W'($urandom_range(0, 40));
  endfunction

  // Pick the next transaction from the predicted phase of a random motor, so
  // most traffic walks each motor through a full move; the rest is noise.
  task automatic pick_item(output logic [CMD_W-1:0] cmd, output logic motor,
                           output logic [TGT_W-1:0] tgt);
    int roll;
    motor = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 9);
    tgt = short_target();
    if ($urandom_range(0, 9) == 0) begin
      cmd = CMD_W'($urandom_range(0, 3));
      // Wide targets only where the move is refused, so no motor gets stuck
      // on a move that would take millions of pulses.
      if (board.phase[motor] != MS_STOPPED) tgt = TGT_W'($urandom);
    end else begin
      case (board.phase[motor])
        MS_STOPPED:  cmd = CMD_MOVE;
        MS_STARTING: cmd = (roll < 6) ? CMD_TICK : CMD_PULSE;
        MS_FULL:     cmd = (roll < 2) ? CMD_TICK : CMD_PULSE;
        MS_BRAKING:  cmd = (roll < 4) ? CMD_TICK : CMD_PULSE;
        default:     cmd = (roll < 1) ? CMD_TICK : CMD_PULSE;
      endcase
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(0, 10);
    // Level zero is favored: it lets a slow motor leave the starting phase at once.
    return (roll > 7) ? '0 : CFG_DATA_W'(roll);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_brake();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_DATA_W'($urandom_range(0, 8));
      4:       return CFG_DATA_W'($urandom_range(0, 60));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Result side: stall at random, then take one transaction and check it.
  initial begin : result_sink
    ramp_result_t got;
    int           stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status       = out_ch.motion_status;
      got.enable       = out_ch.motor_enable;
      got.period_valid = out_ch.period_valid;
      got.period       = out_ch.timer_period;
      got.position     = out_ch.position;
      got.rejected     = out_ch.move_rejected;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    logic             motor;
    logic [TGT_W-1:0] tgt;
    int               random_target;
    int               phase_len;
    board = new();
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_MOVE;
    in_ch.motor        = 1'b0;
    in_ch.target_steps = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_LEVEL0;
    cfg_data  = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unused code and idle motor traffic, then a zero-length move
    // whose braking point saturates at zero, a refused move, braking from above
    // the max rate, the rate wrapping below zero, and the overshoot walk-back.
    send_item(CMD_UNUSED, 1'b1, '0);
    send_item(CMD_TICK, 1'b1, '0);
    send_item(CMD_PULSE, 1'b0, '1);
    send_item(CMD_MOVE, 1'b0, '0);
    send_item(CMD_MOVE, 1'b0, '1);
    send_item(CMD_PULSE, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_PULSE, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    repeat (5) send_item(CMD_PULSE, 1'b0, '0);
    end_phase();

    // Level zero, no brake distance, clamped level on motor 1: the correction
    // rate passes straight to full speed, then braking starts past the target.
    write_reg(CFG_LEVEL0, '0);
    write_reg(CFG_LEVEL1, CFG_DATA_W'(7));
    write_reg(CFG_BRAKE, '0);
    cfg_write <= 1'b0;
    settings_applied++;
    send_item(CMD_MOVE, 1'b0, TGT_W'(1));
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_PULSE, 1'b0, '0);
    send_item(CMD_PULSE, 1'b0, '0);
    end_phase();

    // Top level while braking at the correction rate: the rate hits exactly zero
    // and the timer reloads all ones.
    write_reg(CFG_LEVEL0, CFG_DATA_W'(LEVEL_MAX));
    cfg_write <= 1'b0;
    settings_applied++;
    send_item(CMD_TICK, 1'b0, '0);
    repeat (4) send_item(CMD_PULSE, 1'b0, '0);
    end_phase();

    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_LEVEL0, pick_level());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_LEVEL1, pick_level());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_BRAKE, pick_brake());
        cfg_write <= 1'b0;
        settings_applied++;
      end
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        pick_item(cmd, motor, tgt);
        send_item(cmd, motor, tgt);
      end
      end_phase();
    end

    // Hold on for any stray result before the final check.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.expected_results.size() != 0) begin
      $display("%0d expected results never arrived", board.expected_results.size());
      board.mismatches += board.expected_results.size();
    end
    $display("Drove %0d transactions and checked %0d results across %0d register settings.",
             items_sent, board.results_checked, settings_applied);
    $display("Phases reported: stopped %0d, starting %0d, full %0d, braking %0d, correcting %0d; %0d zero-rate reloads.",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4], board.zero_rate_reloads);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
